[rtl/hfn_pkg.sv]
`timescale 1ns / 1ps

package hfn_pkg;

   localparam int HFN_STEM_LEN = 5;
   localparam int HFN_HASH_LEN = 3;

   localparam int FILL_LEN = 4;
   localparam int EXT_LEN  = 3;

   localparam logic [15:0] HASH_INIT  = 16'h811C;
   localparam logic [15:0] HASH_PRIME = 16'h0193;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h61 && b <= 8'h7A) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_kept(input logic [7:0] u);
      return (u >= 8'h41 && u <= 8'h5A) || (u >= 8'h30 && u <= 8'h39) ||
             (u == 8'h5F) || (u == 8'h2D);
   endfunction

   function automatic logic [7:0] digit_char(input logic [4:0] v);
      logic [7:0] r;
      if (v < 5'd10) begin
         r = 8'h30 + {3'b000, v};
      end else begin
         r = 8'h37 + {3'b000, v};
      end
      return r;
   endfunction

   function automatic logic [7:0] fill_char(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h46;
         2'd1:    r = 8'h49;
         2'd2:    r = 8'h4C;
         default: r = 8'h45;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ext_char(input logic disk, input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = disk ? 8'h44 : 8'h50;
         2'd1:    r = disk ? 8'h38 : 8'h52;
         default: r = disk ? 8'h31 : 8'h47;
      endcase
      return r;
   endfunction

endpackage

[rtl/hfn_req_if.sv]
`timescale 1ns / 1ps

interface hfn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_char;
   logic       end_of_path;
   logic       is_disk_image;

   modport source (output valid, output path_char, output end_of_path,
                   output is_disk_image, input ready);
   modport sink   (input valid, input path_char, input end_of_path,
                   input is_disk_image, output ready);
endinterface

[rtl/hfn_rsp_if.sv]
`timescale 1ns / 1ps

interface hfn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[rtl/hfn_track.sv]
`timescale 1ns / 1ps

module hfn_track
   import hfn_pkg::*;
#(
   parameter int STEM_LEN = HFN_STEM_LEN,
   localparam int CNT_W = $clog2(STEM_LEN + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_en,
   input  logic             clear,
   input  logic [7:0]       path_byte,
   output logic [15:0]      name_hash,
   output logic [CNT_W-1:0] sel_count,
   output logic [7:0]       sel_chars [STEM_LEN]
);

   logic [15:0]      hash_ff;
   logic [15:0]      hash_in;
   logic [CNT_W-1:0] stem_count_ff;
   logic [CNT_W-1:0] saved_count_ff;
   logic             dot_seen_ff;
   logic             at_start_ff;
   logic [7:0]       stem_ff  [STEM_LEN];
   logic [7:0]       saved_ff [STEM_LEN];

   logic       is_slash;
   logic       is_dot;
   logic [7:0] upper;
   logic       keep;
   logic       take_dot;

   assign hash_in  = 16'((hash_ff ^ {8'h00, path_byte}) * HASH_PRIME);
   assign is_slash = (path_byte == CHAR_SLASH);
   assign is_dot   = (path_byte == CHAR_DOT);
   assign upper    = to_upper(path_byte);
   assign keep     = !is_dot && is_kept(upper) && (stem_count_ff < CNT_W'(STEM_LEN));
   assign take_dot = is_dot && !at_start_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hash_ff        <= HASH_INIT;
         stem_count_ff  <= '0;
         saved_count_ff <= '0;
         dot_seen_ff    <= 1'b0;
         at_start_ff    <= 1'b1;
      end else if (byte_en) begin
         hash_ff <= hash_in;
         if (is_slash) begin
            stem_count_ff  <= '0;
            saved_count_ff <= '0;
            dot_seen_ff    <= 1'b0;
            at_start_ff    <= 1'b1;
         end else begin
            if (take_dot) begin
               saved_count_ff <= stem_count_ff;
               dot_seen_ff    <= 1'b1;
            end else if (keep) begin
               stem_count_ff <= stem_count_ff + CNT_W'(1);
            end
            at_start_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_en && !is_slash) begin
         for (int i = 0; i < STEM_LEN; i++) begin
            if (take_dot) begin
               saved_ff[i] <= stem_ff[i];
            end else if (keep && stem_count_ff == CNT_W'(i)) begin
               stem_ff[i] <= upper;
            end
         end
      end
   end

   assign name_hash = hash_ff;
   assign sel_count = dot_seen_ff ? saved_count_ff : stem_count_ff;

   always_comb begin
      for (int i = 0; i < STEM_LEN; i++) begin
         sel_chars[i] = dot_seen_ff ? saved_ff[i] : stem_ff[i];
      end
   end

endmodule

[rtl/hashed_short_file_name.sv]
`timescale 1ns / 1ps
// hashed short file name generator
// req_ch carries one path byte per word; a word with end_of_path set closes
// the path and selects the extension through is_disk_image.
// rsp_ch returns the short name one character per word: stem (or FILE),
// HASH_LEN base-32 hash digits low bits first, a dot, then D81 or PRG;
// last_char marks the final character.
// path bytes: one word per cycle, each folded into the hash and stem
// registers, no result words.
// end word: the name is loaded into the output shift buffer and the first
// character is valid the next cycle; the name, HASH_LEN+5 to
// max(STEM_LEN,4)+HASH_LEN+4 characters, drains at one character per cycle
// while the receiver is ready. path bytes of the next name are taken while the
// buffer drains; a second end word waits until the buffer is empty.
// reset: synchronous, clears the hash and stem state and empties the output
// buffer. when the receiver stalls, the current character holds and the buffer
// does not advance.

module hashed_short_file_name
   import hfn_pkg::*;
#(
   parameter int STEM_LEN = HFN_STEM_LEN,
   parameter int HASH_LEN = HFN_HASH_LEN
) (
   input  logic    clock,
   input  logic    reset,
   hfn_req_if.sink   req_ch,
   hfn_rsp_if.source rsp_ch
);

   localparam int CNT_W     = $clog2(STEM_LEN + 1);
   localparam int MAX_STEM  = (STEM_LEN > FILL_LEN) ? STEM_LEN : FILL_LEN;
   localparam int TAIL_LEN  = HASH_LEN + 1 + EXT_LEN;
   localparam int MAX_OUT   = MAX_STEM + TAIL_LEN;
   localparam int OUT_LEN_W = $clog2(MAX_OUT + 1);

   logic             req_take;
   logic             byte_en;
   logic             end_take;
   logic             rsp_take;
   logic [15:0]      name_hash;
   logic [CNT_W-1:0] sel_count;
   logic [7:0]       sel_chars [STEM_LEN];

   logic [7:0]           tail [TAIL_LEN];
   logic [OUT_LEN_W-1:0] slen;
   logic [OUT_LEN_W-1:0] load_len;
   logic [7:0]           load_chars [MAX_OUT];

   logic [7:0]           buf_ff [MAX_OUT];
   logic [OUT_LEN_W-1:0] left_ff;

   assign req_ch.ready = (left_ff == '0) || !req_ch.end_of_path;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign byte_en      = req_take && !req_ch.end_of_path;
   assign end_take     = req_take && req_ch.end_of_path;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   hfn_track #(
      .STEM_LEN (STEM_LEN)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .clear     (end_take),
      .path_byte (req_ch.path_char),
      .name_hash (name_hash),
      .sel_count (sel_count),
      .sel_chars (sel_chars)
   );

   // hash digits, dot and extension
   always_comb begin
      for (int k = 0; k < TAIL_LEN; k++) begin
         if (k < HASH_LEN) begin
            tail[k] = digit_char(name_hash[5*k +: 5]);
         end else if (k == HASH_LEN) begin
            tail[k] = CHAR_DOT;
         end else begin
            tail[k] = ext_char(req_ch.is_disk_image, 2'(k - HASH_LEN - 1));
         end
      end
   end

   assign slen     = (sel_count == '0) ? OUT_LEN_W'(FILL_LEN) : OUT_LEN_W'(sel_count);
   assign load_len = slen + OUT_LEN_W'(TAIL_LEN);

   // place the tail right after the stem
   always_comb begin
      for (int p = 0; p < MAX_OUT; p++) begin
         load_chars[p] = 8'h00;
         if (p < STEM_LEN && sel_count != '0 && OUT_LEN_W'(p) < slen) begin
            load_chars[p] = sel_chars[(p < STEM_LEN) ? p : 0];
         end
         if (p < FILL_LEN && sel_count == '0) begin
            load_chars[p] = fill_char(2'(p));
         end
         for (int j = 0; j < TAIL_LEN; j++) begin
            if (p >= j && OUT_LEN_W'(p - j) == slen) begin
               load_chars[p] = tail[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (end_take) begin
         left_ff <= load_len;
      end else if (rsp_take) begin
         left_ff <= left_ff - OUT_LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (end_take) begin
         for (int i = 0; i < MAX_OUT; i++) begin
            buf_ff[i] <= load_chars[i];
         end
      end else if (rsp_take) begin
         for (int i = 0; i < MAX_OUT - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   assign rsp_ch.valid     = (left_ff != '0);
   assign rsp_ch.out_char  = buf_ff[0];
   assign rsp_ch.last_char = (left_ff == OUT_LEN_W'(1));

   a_end_loads: assert property (@(posedge clock) disable iff (reset)
      end_take |=> rsp_ch.valid)
      else $error("name not loaded after end word");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      end_take |-> !rsp_ch.valid)
      else $error("end word taken while buffer busy");

   a_drain_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_ch.last_char) |=> rsp_ch.valid)
      else $error("name ended before last character");

   a_drain_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_ch.last_char) |=> !rsp_ch.valid)
      else $error("word after last character");

endmodule
